// ----- sv/desa_pkg.sv -----
// Package for the double-ended stack allocator.
// Holds widths, sizes, command and status codes, and the controller state type.
`default_nettype none

package desa_pkg;

    localparam int POOL_BYTES  = 65536;
    localparam int STACK_DEPTH = 64;

    localparam int AW     = 17;
    localparam int IDX_W  = $clog2(STACK_DEPTH);
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [APB_AW-1:0] REG_POOL_SIZE = 3'd0;

    localparam logic [AW-1:0] POOL_RESET = 17'd65536;
    localparam logic [AW-1:0] POOL_CAP   =
        (POOL_BYTES > 131071) ? {AW{1'b1}} : AW'(POOL_BYTES);
    localparam logic [AW-1:0] HIGH_RESET =
        (POOL_BYTES < 65536) ? AW'(POOL_BYTES) : POOL_RESET;

    typedef enum logic [2:0] {
        CMD_ALLOC_LOW  = 3'd0,
        CMD_ALLOC_HIGH = 3'd1,
        CMD_FREE_LOW   = 3'd2,
        CMD_FREE_HIGH  = 3'd3,
        CMD_CLEAR      = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_OOM   = 3'd1,
        ST_EMPTY = 3'd2,
        ST_WRONG = 3'd3,
        ST_FULL  = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

endpackage

`default_nettype wire

// ----- sv/desa_cmd_if.sv -----
// Request channel of the allocator: valid/ready handshake and command payload.
// Depends on desa_pkg for field widths.
`default_nettype none

interface desa_cmd_if
    import desa_pkg::*;
;
    logic          valid;
    logic          ready;
    logic [2:0]    command;
    logic [AW-1:0] chunk_size;
    logic [AW-1:0] block_offset;

    modport source (output valid, output command, output chunk_size,
                    output block_offset, input ready);
    modport sink   (input valid, input command, input chunk_size,
                    input block_offset, output ready);
endinterface

`default_nettype wire

// ----- sv/desa_rsp_if.sv -----
// Result channel of the allocator: valid/ready handshake and result payload.
// Depends on desa_pkg for field widths.
`default_nettype none

interface desa_rsp_if
    import desa_pkg::*;
;
    logic          valid;
    logic          ready;
    logic [AW-1:0] offset;
    logic [2:0]    status;

    modport source (output valid, output offset, output status, input ready);
    modport sink   (input valid, input offset, input status, output ready);
endinterface

`default_nettype wire

// ----- sv/desa_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module desa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- sv/desa_cfg.sv -----
// APB-style configuration register block holding pool_size.
// Depends on desa_pkg; supplies the capped pool size to the controller.
`default_nettype none

module desa_cfg
    import desa_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [APB_AW-1:0]  paddr,
    input  wire  [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready,
    output logic [AW-1:0]      o_pool_used
);

    logic [AW-1:0] r_pool_size;
    logic          w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr == REG_POOL_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_size <= POOL_RESET;
        end else if (w_wr) begin
            r_pool_size <= pwdata[AW-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == REG_POOL_SIZE) begin
            prdata = {{(APB_DW-AW){1'b0}}, r_pool_size};
        end
    end

    assign o_pool_used = (r_pool_size > POOL_CAP) ? POOL_CAP : r_pool_size;

endmodule

`default_nettype wire

// ----- sv/desa_ctrl.sv -----
// Allocator controller: markers, stack counts, size stacks and result register.
// Depends on desa_pkg, desa_cmd_if, desa_rsp_if and desa_ram.
`default_nettype none

module desa_ctrl
    import desa_pkg::*;
(
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire  [AW-1:0] i_pool_used,
    desa_cmd_if.sink      i_cmd,
    desa_rsp_if.source    o_rsp
);

    t_state          r_state, n_state;
    t_cmd            r_cmd;
    logic [AW-1:0]   r_chunk;
    logic [AW-1:0]   r_addr;
    logic [AW-1:0]   r_low, n_low;
    logic [AW-1:0]   r_high, n_high;
    logic [CNT_W-1:0] r_lcnt, n_lcnt;
    logic [CNT_W-1:0] r_hcnt, n_hcnt;
    logic            r_out_valid;
    logic [AW-1:0]   r_out_offset, n_out_offset;
    t_status         r_out_status, n_out_status;

    logic            w_accept;
    logic            w_fire;
    logic            w_we_low, w_we_high;
    logic [AW-1:0]   w_room;
    logic            w_fit;
    logic [AW-1:0]   w_low_top, w_high_top;
    logic [CNT_W-1:0] w_lcnt_m1, w_hcnt_m1;

    assign w_lcnt_m1 = r_lcnt - CNT_W'(1);
    assign w_hcnt_m1 = r_hcnt - CNT_W'(1);

    desa_ram #(.WIDTH(AW), .DEPTH(STACK_DEPTH)) u_low_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_low),
        .i_waddr (r_lcnt[IDX_W-1:0]),
        .i_wdata (r_chunk),
        .i_raddr (w_lcnt_m1[IDX_W-1:0]),
        .o_rdata (w_low_top)
    );

    desa_ram #(.WIDTH(AW), .DEPTH(STACK_DEPTH)) u_high_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_high),
        .i_waddr (r_hcnt[IDX_W-1:0]),
        .i_wdata (r_chunk),
        .i_raddr (w_hcnt_m1[IDX_W-1:0]),
        .o_rdata (w_high_top)
    );

    assign i_cmd.ready  = (r_state == S_IDLE);
    assign w_accept     = i_cmd.valid && i_cmd.ready;
    assign w_fire       = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.offset = r_out_offset;
    assign o_rsp.status = r_out_status;

    assign w_room = r_high - r_low;
    assign w_fit  = (r_chunk <= w_room);

    always_comb begin
        n_low        = r_low;
        n_high       = r_high;
        n_lcnt       = r_lcnt;
        n_hcnt       = r_hcnt;
        n_out_offset = '0;
        n_out_status = ST_OK;
        w_we_low     = 1'b0;
        w_we_high    = 1'b0;
        n_state      = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_fire) begin
                    n_state = S_IDLE;
                    case (r_cmd)
                        CMD_ALLOC_LOW: begin
                            if (!w_fit) begin
                                n_out_status = ST_OOM;
                            end else if (r_lcnt >= CNT_W'(STACK_DEPTH)) begin
                                n_out_status = ST_FULL;
                            end else begin
                                n_out_offset = r_low;
                                n_low        = r_low + r_chunk;
                                n_lcnt       = r_lcnt + CNT_W'(1);
                                w_we_low     = 1'b1;
                            end
                        end
                        CMD_ALLOC_HIGH: begin
                            if (!w_fit) begin
                                n_out_status = ST_OOM;
                            end else if (r_hcnt >= CNT_W'(STACK_DEPTH)) begin
                                n_out_status = ST_FULL;
                            end else begin
                                n_high       = r_high - r_chunk;
                                n_out_offset = r_high - r_chunk;
                                n_hcnt       = r_hcnt + CNT_W'(1);
                                w_we_high    = 1'b1;
                            end
                        end
                        CMD_FREE_LOW: begin
                            if (r_lcnt == '0) begin
                                n_out_status = ST_EMPTY;
                            end else if (r_addr != (r_low - w_low_top)) begin
                                n_out_status = ST_WRONG;
                            end else begin
                                n_low  = r_low - w_low_top;
                                n_lcnt = w_lcnt_m1;
                            end
                        end
                        CMD_FREE_HIGH: begin
                            if (r_hcnt == '0) begin
                                n_out_status = ST_EMPTY;
                            end else if (r_addr != r_high) begin
                                n_out_status = ST_WRONG;
                            end else begin
                                n_high = r_high + w_high_top;
                                n_hcnt = w_hcnt_m1;
                            end
                        end
                        CMD_CLEAR: begin
                            n_low  = '0;
                            n_high = i_pool_used;
                            n_lcnt = '0;
                            n_hcnt = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low       <= '0;
            r_high      <= HIGH_RESET;
            r_lcnt      <= '0;
            r_hcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_low  <= n_low;
            r_high <= n_high;
            r_lcnt <= n_lcnt;
            r_hcnt <= n_hcnt;
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd   <= t_cmd'(i_cmd.command);
            r_chunk <= i_cmd.chunk_size;
            r_addr  <= i_cmd.block_offset;
        end
        if (w_fire) begin
            r_out_offset <= n_out_offset;
            r_out_status <= n_out_status;
        end
    end

    a_markers_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_high)
        else $error("low marker above high marker");

    a_counts_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lcnt <= CNT_W'(STACK_DEPTH)) && (r_hcnt <= CNT_W'(STACK_DEPTH)))
        else $error("stack count beyond depth");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("executed request produced no result");

    a_push_low_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we_low |=> (r_lcnt == $past(r_lcnt) + CNT_W'(1)))
        else $error("low push did not advance count");

endmodule

`default_nettype wire

// ----- sv/double_ended_stack_allocator.sv -----
// Double-ended stack allocator, top level. A request is accepted in the idle
// state and executed in the exec state, which covers the registered read of the
// size-stack RAM ahead of the free check; no new request is taken until it has
// executed. Reset is synchronous, active low: markers, counts and pool_size
// return to their reset values; stack RAM contents are not cleared.
`default_nettype none

module double_ended_stack_allocator
    import desa_pkg::*;
(
    input  wire               i_clk,
    input  wire               i_rst_n,
    desa_cmd_if.sink          i_cmd,
    desa_rsp_if.source        o_rsp,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire  [APB_AW-1:0] paddr,
    input  wire  [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [AW-1:0] w_pool_used;

    desa_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_pool_used (w_pool_used)
    );

    desa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pool_used (w_pool_used),
        .i_cmd       (i_cmd),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Testbench for double_ended_stack_allocator: directed commands, size-stack fill,
// pool_size settings and long random traffic, each result checked in order.
// Depends on desa_pkg, desa_cmd_if and desa_rsp_if.

module testbench;
    import desa_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int MAX_GAP      = 18;
    localparam int DRAIN_CYCLES = 6;
    localparam int MAX_LOGGED   = 40;
    localparam int PHASE_ITEMS  = 120;

    localparam logic [AW-1:0] FIELD_MAX  = {AW{1'b1}};
    localparam logic [AW-1:0] POOL_AFTER_RESET = 17'd65536;

    localparam logic [2:0] CMD_SPARE_5 = 3'd5;
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [AW-1:0] offset;
        t_status       status;
    } t_outcome;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    desa_cmd_if cmd_if ();
    desa_rsp_if rsp_if ();

    double_ended_stack_allocator u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // allocator state as the bench sees it
    logic [AW-1:0] pool_reg;
    logic [AW-1:0] low_mark;
    logic [AW-1:0] high_mark;
    logic [AW-1:0] low_sizes  [STACK_DEPTH];
    logic [AW-1:0] high_sizes [STACK_DEPTH];
    int            low_depth;
    int            high_depth;

    t_outcome    pending_outcomes [$];
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned rsp_stall   = 0;
    bit          steady_flow = 1'b0;

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int unsigned draw_gap();
        if (steady_flow || $urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    function automatic logic [AW-1:0] pool_in_use();
        if (int'(pool_reg) > POOL_BYTES) return AW'(POOL_BYTES);
        return pool_reg;
    endfunction

    function automatic void clear_allocator();
        low_mark   = '0;
        high_mark  = pool_in_use();
        low_depth  = 0;
        high_depth = 0;
    endfunction

    function automatic t_outcome predict_outcome(input logic [2:0]    cmd,
                                                 input logic [AW-1:0] chunk,
                                                 input logic [AW-1:0] offs);
        t_outcome      r;
        logic [AW-1:0] room;
        logic [AW-1:0] top;
        r.offset = '0;
        r.status = ST_OK;
        room     = high_mark - low_mark;
        case (cmd)
            CMD_ALLOC_LOW: begin
                if (chunk > room) r.status = ST_OOM;
                else if (low_depth >= STACK_DEPTH) r.status = ST_FULL;
                else begin
                    r.offset = low_mark;
                    low_sizes[low_depth] = chunk;
                    low_depth++;
                    low_mark = low_mark + chunk;
                end
            end
            CMD_ALLOC_HIGH: begin
                if (chunk > room) r.status = ST_OOM;
                else if (high_depth >= STACK_DEPTH) r.status = ST_FULL;
                else begin
                    high_mark = high_mark - chunk;
                    r.offset = high_mark;
                    high_sizes[high_depth] = chunk;
                    high_depth++;
                end
            end
            CMD_FREE_LOW: begin
                if (low_depth == 0) r.status = ST_EMPTY;
                else begin
                    top = low_sizes[low_depth-1];
                    if (offs != low_mark - top) r.status = ST_WRONG;
                    else begin
                        low_mark = low_mark - top;
                        low_depth--;
                    end
                end
            end
            CMD_FREE_HIGH: begin
                if (high_depth == 0) r.status = ST_EMPTY;
                else if (offs != high_mark) r.status = ST_WRONG;
                else begin
                    high_mark = high_mark + high_sizes[high_depth-1];
                    high_depth--;
                end
            end
            CMD_CLEAR: begin
                clear_allocator();
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        fail_count++;
        if (fail_count <= MAX_LOGGED)
            $display("mismatch on %0s: got %0d, expected %0d at cycle %0d",
                     what, got, want, cycle_count);
    endtask

    always @(posedge i_clk) begin : result_check
        t_outcome want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_outcomes.size() == 0) begin
                report_mismatch("result with no request pending", rsp_if.status, 0);
            end else begin
                want = pending_outcomes.pop_front();
                if (rsp_if.offset !== want.offset)
                    report_mismatch("offset", rsp_if.offset, want.offset);
                if (rsp_if.status !== want.status)
                    report_mismatch("status", rsp_if.status, want.status);
            end
        end
        if (!i_rst_n) begin
            rsp_stall = 0;
            rsp_if.ready <= 1'b0;
        end else if (rsp_if.ready && rsp_if.valid) begin
            rsp_stall = draw_gap();
            rsp_if.ready <= (rsp_stall == 0);
        end else if (!rsp_if.ready) begin
            if (rsp_stall != 0) rsp_stall--;
            rsp_if.ready <= (rsp_stall == 0);
        end
    end

    task automatic send_request(input logic [2:0]    cmd,
                                input logic [AW-1:0] chunk,
                                input logic [AW-1:0] offs);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.command      <= cmd;
        cmd_if.chunk_size   <= chunk;
        cmd_if.block_offset <= offs;
        do @(posedge i_clk); while (!cmd_if.ready);
        pending_outcomes.push_back(predict_outcome(cmd, chunk, offs));
    endtask

    task automatic wait_idle();
        cmd_if.valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_pool_size(input logic [APB_DW-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_POOL_SIZE;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pool_reg = value[AW-1:0];
    endtask

    task automatic send_random_command(input int unsigned chunk_cap);
        int unsigned   pick;
        logic [2:0]    cmd;
        logic [AW-1:0] chunk;
        logic [AW-1:0] offs;
        pick  = $urandom_range(0, 99);
        chunk = AW'($urandom_range(0, chunk_cap));
        offs  = AW'($urandom);
        if (pick < 30) begin
            cmd = CMD_ALLOC_LOW;
        end else if (pick < 60) begin
            cmd = CMD_ALLOC_HIGH;
        end else if (pick < 75) begin
            cmd = CMD_FREE_LOW;
            if (low_depth != 0) offs = low_mark - low_sizes[low_depth-1];
        end else if (pick < 89) begin
            cmd  = CMD_FREE_HIGH;
            offs = high_mark;
        end else if (pick < 93) begin
            // near miss on the top block
            cmd = $urandom_range(0, 1) ? CMD_FREE_LOW : CMD_FREE_HIGH;
            if (cmd == CMD_FREE_HIGH)
                offs = high_mark + ($urandom_range(0, 1) ? AW'(1) : {AW{1'b1}});
            else if (low_depth != 0)
                offs = low_mark - low_sizes[low_depth-1] + AW'(1);
        end else if (pick < 95) begin
            cmd = CMD_CLEAR;
        end else if (pick < 98) begin
            cmd   = $urandom_range(0, 1) ? CMD_ALLOC_LOW : CMD_ALLOC_HIGH;
            chunk = AW'($urandom);
        end else begin
            cmd = 3'($urandom_range(CMD_SPARE_5, CMD_SPARE_7));
        end
        send_request(cmd, chunk, offs);
    endtask

    task automatic test_directed_commands();
        steady_flow = 1'b0;
        send_request(CMD_FREE_LOW, '0, '0);
        send_request(CMD_FREE_HIGH, '0, POOL_AFTER_RESET);
        send_request(CMD_ALLOC_LOW, '0, '0);
        send_request(CMD_ALLOC_LOW, 17'd100, '0);
        send_request(CMD_ALLOC_HIGH, '0, '0);
        send_request(CMD_ALLOC_HIGH, 17'd200, '0);
        send_request(CMD_FREE_HIGH, '0, high_mark + AW'(1));
        send_request(CMD_FREE_HIGH, '0, high_mark);
        send_request(CMD_FREE_HIGH, '0, high_mark);
        send_request(CMD_FREE_LOW, '0, 17'd1);
        send_request(CMD_FREE_LOW, '0, '0);
        send_request(CMD_FREE_LOW, '0, '0);
        send_request(CMD_ALLOC_LOW, POOL_AFTER_RESET, '0);
        send_request(CMD_ALLOC_HIGH, 17'd1, '0);
        send_request(CMD_ALLOC_HIGH, '0, '0);
        send_request(CMD_SPARE_5, FIELD_MAX, FIELD_MAX);
        send_request(CMD_SPARE_6, FIELD_MAX, FIELD_MAX);
        send_request(CMD_SPARE_7, '0, '0);
        send_request(CMD_CLEAR, FIELD_MAX, FIELD_MAX);
        send_request(CMD_ALLOC_HIGH, FIELD_MAX, '0);
        send_request(CMD_ALLOC_HIGH, POOL_AFTER_RESET, '0);
        send_request(CMD_FREE_HIGH, '0, FIELD_MAX);
        send_request(CMD_FREE_HIGH, '0, '0);
        send_request(CMD_FREE_LOW, '0, FIELD_MAX);
        send_request(CMD_CLEAR, '0, '0);
    endtask

    task automatic test_size_stack_full();
        int i;
        send_request(CMD_CLEAR, '0, '0);
        for (i = 0; i < STACK_DEPTH; i++)
            send_request(CMD_ALLOC_LOW, AW'($urandom_range(0, 400)), '0);
        send_request(CMD_ALLOC_LOW, '0, '0);
        send_request(CMD_ALLOC_LOW, FIELD_MAX, '0);
        for (i = 0; i < STACK_DEPTH; i++)
            send_request(CMD_ALLOC_HIGH, AW'($urandom_range(0, 400)), '0);
        send_request(CMD_ALLOC_HIGH, 17'd1, '0);
        send_request(CMD_ALLOC_HIGH, FIELD_MAX, '0);
        send_request(CMD_FREE_LOW, '0, low_mark - low_sizes[low_depth-1]);
        send_request(CMD_ALLOC_LOW, 17'd3, '0);
        while (high_depth != 0) send_request(CMD_FREE_HIGH, '0, high_mark);
        while (low_depth != 0)
            send_request(CMD_FREE_LOW, '0, low_mark - low_sizes[low_depth-1]);
    endtask

    task automatic test_pool_size_settings();
        logic [APB_DW-1:0] settings [6] = '{32'd0, 32'd16, 32'd65535, 32'h0001_FFFF,
                                            32'hFFFE_0400, 32'd65536};
        int i;
        for (i = 0; i < 6; i++) begin
            wait_idle();
            write_pool_size(settings[i]);
            // hold the old pool until the next clear
            send_request(CMD_ALLOC_HIGH, AW'($urandom_range(0, 64)), '0);
            send_request(CMD_CLEAR, '0, '0);
            send_request(CMD_ALLOC_HIGH, pool_in_use() + AW'(1), '0);
            send_request(CMD_ALLOC_LOW, pool_in_use(), '0);
            send_request(CMD_ALLOC_HIGH, '0, '0);
            send_request(CMD_ALLOC_HIGH, 17'd1, '0);
            send_request(CMD_FREE_HIGH, '0, high_mark);
            send_request(CMD_FREE_LOW, '0, '0);
        end
    endtask

    task automatic test_random_traffic();
        logic [APB_DW-1:0] plan [5] = '{32'd65536, 32'd4096, 32'd64, 32'd20000,
                                        32'd65536};
        int i;
        int n;
        for (i = 0; i < 5; i++) begin
            wait_idle();
            write_pool_size(plan[i]);
            send_request(CMD_CLEAR, '0, '0);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
                send_random_command(pool_in_use() / 40 + 2);
            end
        end
        steady_flow = 1'b0;
    endtask

    initial begin
        cmd_if.valid        = 1'b0;
        cmd_if.command      = CMD_CLEAR;
        cmd_if.chunk_size   = '0;
        cmd_if.block_offset = '0;
        rsp_if.ready        = 1'b0;
        pool_reg            = POOL_AFTER_RESET;
        clear_allocator();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_commands();
        test_size_stack_full();
        test_pool_size_settings();
        test_random_traffic();
        wait_idle();
        if (fail_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
